### sv/multilevel_feedback_queue_scheduler_core_assert.svh
// assertion macros shared by the scheduler core modules
// expects clk and rst_n in the scope of each use
`ifndef MULTILEVEL_FEEDBACK_QUEUE_SCHEDULER_CORE_ASSERT_SVH
`define MULTILEVEL_FEEDBACK_QUEUE_SCHEDULER_CORE_ASSERT_SVH

// same-cycle implication
`define MFQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MFQ_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/mfq_pkg.sv
// types, constants and helpers of the feedback queue scheduler
// no dependencies; imported by every scheduler module
`timescale 1ns / 1ps

package mfq_pkg;

    // sizing
    localparam int LEVELS      = 4;
    localparam int QUEUE_DEPTH = 16;
    localparam int ID_BITS     = 8;
    localparam int TIME_BITS   = 16;

    localparam int LVL_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int IDX_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W    = LVL_W + IDX_W;
    localparam int MEM_DEPTH = LEVELS * (1 << IDX_W);

    // port widths fixed by the interface
    localparam int JOB_ID_W   = 8;
    localparam int SVC_IN_W   = 16;
    localparam int TIME_OUT_W = 32;
    localparam int STATUS_W   = 2;
    localparam int RUN_LVL_W  = 2;
    localparam int QUANTUM_W  = 8;
    localparam int CFG_IDX_W  = 3;

    // quantum registers, the last one serves all deeper levels
    localparam int NUM_QUANTA = 4;
    localparam int QIDX_W     = $clog2(NUM_QUANTA);
    localparam logic [NUM_QUANTA-1:0][QUANTUM_W-1:0] QUANTUM_RESET =
        {8'd8, 8'd4, 8'd2, 8'd1};
    localparam logic [QUANTUM_W-1:0] OVERHEAD_RESET = '0;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM_LAST    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SWITCH_OVERHEAD = 3'd4;

    // command codes
    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_RAN     = 2'd0,
        ST_IDLE    = 2'd1,
        ST_ADDED   = 2'd2,
        ST_REFUSED = 2'd3
    } status_t;

    typedef struct packed {
        logic [ID_BITS-1:0]   id;
        logic [TIME_BITS-1:0] svc;
        logic [TIME_BITS-1:0] rem;
    } job_t;

    typedef struct packed {
        logic                command;
        logic [JOB_ID_W-1:0] job_id;
        logic [SVC_IN_W-1:0] work_units;
    } item_t;

    typedef struct packed {
        logic [NUM_QUANTA-1:0][QUANTUM_W-1:0] quantum;
        logic [QUANTUM_W-1:0]                 overhead;
    } cfg_t;

    // handshake control from the top level to the scheduler
    typedef struct packed {
        logic issue;
        logic commit;
    } ctl_t;

    typedef struct packed {
        status_t               status;
        logic [ID_BITS-1:0]    run_id;
        logic                  switched;
        logic                  first;
        logic [ID_BITS-1:0]    fin_id;
        logic [TIME_OUT_W-1:0] start;
        logic [LVL_W-1:0]      lvl;
    } result_t;

    // slice length of a level, zero quantum acts as one
    function automatic logic [QUANTUM_W-1:0] slice_of(
        input logic [LVL_W-1:0]                    lvl,
        input logic [NUM_QUANTA-1:0][QUANTUM_W-1:0] q
    );
        logic [QUANTUM_W-1:0] s;
        s = q[NUM_QUANTA-1];
        for (int i = 0; i < NUM_QUANTA - 1; i++)
        begin
            if (32'(lvl) == i)
            begin
                s = q[i];
            end
        end
        return (s == '0) ? QUANTUM_W'(1) : s;
    endfunction

endpackage

### sv/mfq_qmem.sv
// job store of all level queues, one write and one registered read port
// depends on mfq_pkg
`timescale 1ns / 1ps

module mfq_qmem (
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [mfq_pkg::ADDR_W-1:0] wr_addr,
    input  mfq_pkg::job_t         wr_data,
    input  logic                  rd_en,
    input  logic [mfq_pkg::ADDR_W-1:0] rd_addr,
    output mfq_pkg::job_t         rd_data
);
    import mfq_pkg::*;

    job_t queue_mem [MEM_DEPTH];
    job_t rd_data_reg;

    // read returns the old entry when the same slot is written
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            queue_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= queue_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/mfq_sched.sv
// queue pointers, running job and dispatch decisions of the scheduler
// depends on mfq_pkg, mfq_qmem and the assertion macro header
`timescale 1ns / 1ps
`include "multilevel_feedback_queue_scheduler_core_assert.svh"

module mfq_sched (
    input  logic             clk,
    input  logic             rst_n,
    input  mfq_pkg::ctl_t    ctl,
    input  mfq_pkg::item_t   item,
    input  mfq_pkg::cfg_t    cfg,
    output mfq_pkg::result_t res
);
    import mfq_pkg::*;

    typedef enum logic [1:0] {
        PK_ADDED,
        PK_REFUSED,
        PK_IDLE,
        PK_RUN
    } plan_kind_t;

    typedef struct packed {
        plan_kind_t         kind;
        logic               from_mem;
        logic               cmp_id;
        logic               sw_fin;
        logic [LVL_W-1:0]   new_lvl;
        logic [QUANTUM_W-1:0] slice_base;
        logic [ID_BITS-1:0] fin_id;
    } plan_t;

    // pointers and running state
    logic [CNT_W-1:0]      cnt_reg  [LEVELS];
    logic [CNT_W-1:0]      cnt_next [LEVELS];
    logic [IDX_W-1:0]      head_reg [LEVELS];
    logic [IDX_W-1:0]      head_next[LEVELS];
    job_t                  run_reg;
    logic [LVL_W-1:0]      run_lvl_reg;
    logic [QUANTUM_W-1:0]  slice_reg;
    logic [TIME_OUT_W-1:0] time_reg;
    plan_t                 plan_reg;
    plan_t                 plan_next;

    // issue-side decode
    logic                  fin;
    logic                  active;
    logic                  top_any;
    logic                  tgt_full;
    logic                  bypass;
    logic                  reload;
    logic                  do_push;
    logic                  do_pop;
    logic                  cnt_over;
    logic [LVL_W-1:0]      top_lvl;
    logic [LVL_W-1:0]      target;
    logic [LVL_W-1:0]      ptop;
    logic [LVL_W-1:0]      push_lvl;
    logic [LVL_W-1:0]      pop_lvl;
    logic [CNT_W-1:0]      cnt_tgt;
    logic [CNT_W-1:0]      cnt_push;
    logic [IDX_W-1:0]      head_push;
    logic [IDX_W-1:0]      head_pop;
    logic [IDX_W:0]        tail_sum;
    logic [IDX_W-1:0]      tail_push;
    logic [ID_BITS-1:0]    add_id;
    logic [TIME_BITS-1:0]  add_svc;
    job_t                  push_job;

    // commit-side values
    job_t                  rd_job;
    job_t                  nxt;
    logic                  sw;
    logic [TIME_OUT_W-1:0] start_t;

    assign add_id  = ID_BITS'(item.job_id);
    assign add_svc = TIME_BITS'(item.work_units);

    // dispatch decision from the current pointers and running job
    always_comb
    begin
        fin     = (run_reg.id != '0) && (run_reg.rem == '0);
        active  = (run_reg.id != '0) && !fin;

        top_any = 1'b0;
        top_lvl = '0;
        for (int l = LEVELS - 1; l >= 0; l--)
        begin
            if (cnt_reg[l] != '0)
            begin
                top_any = 1'b1;
                top_lvl = LVL_W'(l);
            end
        end

        target = (run_lvl_reg == LVL_W'(LEVELS - 1)) ? run_lvl_reg
                                                      : run_lvl_reg + LVL_W'(1);
        cnt_tgt = '0;
        for (int l = 0; l < LEVELS; l++)
        begin
            if (LVL_W'(l) == target)
            begin
                cnt_tgt = cnt_reg[l];
            end
        end
        tgt_full = (cnt_tgt == CNT_W'(QUEUE_DEPTH));
        ptop     = (target < top_lvl) ? target : top_lvl;

        do_push  = 1'b0;
        do_pop   = 1'b0;
        bypass   = 1'b0;
        reload   = 1'b0;
        push_lvl = '0;
        pop_lvl  = '0;
        push_job = run_reg;

        plan_next.kind     = PK_RUN;
        plan_next.from_mem = 1'b0;
        plan_next.cmp_id   = 1'b0;
        plan_next.sw_fin   = fin;
        plan_next.new_lvl  = run_lvl_reg;
        plan_next.fin_id   = fin ? run_reg.id : '0;

        priority if (item.command == CMD_ADD)
        begin
            if ((add_id == '0) || (add_svc == '0) ||
                (cnt_reg[0] == CNT_W'(QUEUE_DEPTH)))
            begin
                plan_next.kind = PK_REFUSED;
            end
            else
            begin
                plan_next.kind = PK_ADDED;
                do_push        = 1'b1;
                push_job.id    = add_id;
                push_job.svc   = add_svc;
                push_job.rem   = add_svc;
            end
        end
        else if (!active)
        begin
            // processor free: take the front of the top level
            if (!top_any)
            begin
                plan_next.kind = PK_IDLE;
            end
            else
            begin
                do_pop             = 1'b1;
                pop_lvl            = top_lvl;
                plan_next.from_mem = 1'b1;
                plan_next.new_lvl  = top_lvl;
                reload             = 1'b1;
            end
        end
        else if (slice_reg == '0)
        begin
            // slice used up
            reload = 1'b1;
            if (!top_any)
            begin
                plan_next.new_lvl = run_lvl_reg;
            end
            else if (!tgt_full)
            begin
                // demote, then take the new top front
                do_push            = 1'b1;
                push_lvl           = target;
                do_pop             = 1'b1;
                pop_lvl            = ptop;
                bypass             = (ptop == target) && (cnt_tgt == '0);
                plan_next.from_mem = !bypass;
                plan_next.cmp_id   = 1'b1;
                plan_next.new_lvl  = ptop;
            end
            else if (top_lvl == target)
            begin
                // full lower queue: swap with its front through the same slot
                do_push            = 1'b1;
                push_lvl           = target;
                do_pop             = 1'b1;
                pop_lvl            = target;
                plan_next.from_mem = 1'b1;
                plan_next.cmp_id   = 1'b1;
                plan_next.new_lvl  = target;
            end
            else
            begin
                plan_next.new_lvl = run_lvl_reg;
            end
        end
        else
        begin
            // slice left: the running job keeps going
            plan_next.kind = PK_RUN;
        end

        plan_next.slice_base = reload ? slice_of(plan_next.new_lvl, cfg.quantum)
                                      : slice_reg;

        // pointer selection for the memory addresses
        cnt_push  = '0;
        head_push = '0;
        head_pop  = '0;
        for (int l = 0; l < LEVELS; l++)
        begin
            if (LVL_W'(l) == push_lvl)
            begin
                cnt_push  = cnt_reg[l];
                head_push = head_reg[l];
            end
            if (LVL_W'(l) == pop_lvl)
            begin
                head_pop = head_reg[l];
            end
        end
        tail_sum  = (IDX_W + 1)'(head_push) + (IDX_W + 1)'(cnt_push);
        tail_push = (tail_sum >= (IDX_W + 1)'(QUEUE_DEPTH))
                  ? IDX_W'(tail_sum - (IDX_W + 1)'(QUEUE_DEPTH))
                  : IDX_W'(tail_sum);
    end

    // per-level pointer updates
    always_comb
    begin
        cnt_over = 1'b0;
        for (int l = 0; l < LEVELS; l++)
        begin
            cnt_next[l]  = cnt_reg[l];
            head_next[l] = head_reg[l];
            if (do_push && (push_lvl == LVL_W'(l)) && !(do_pop && (pop_lvl == LVL_W'(l))))
            begin
                cnt_next[l] = cnt_reg[l] + CNT_W'(1);
            end
            if (do_pop && (pop_lvl == LVL_W'(l)))
            begin
                if (!(do_push && (push_lvl == LVL_W'(l))))
                begin
                    cnt_next[l] = cnt_reg[l] - CNT_W'(1);
                end
                head_next[l] = (head_reg[l] == IDX_W'(QUEUE_DEPTH - 1))
                             ? '0 : head_reg[l] + IDX_W'(1);
            end
            if (cnt_reg[l] > CNT_W'(QUEUE_DEPTH))
            begin
                cnt_over = 1'b1;
            end
        end
    end

    mfq_qmem u_qmem (
        .clk     (clk),
        .wr_en   (ctl.issue && do_push),
        .wr_addr ({push_lvl, tail_push}),
        .wr_data (push_job),
        .rd_en   (ctl.issue && do_pop && !bypass),
        .rd_addr ({pop_lvl, head_pop}),
        .rd_data (rd_job)
    );

    // commit: pick the job that runs and form the result beat
    always_comb
    begin
        nxt     = plan_reg.from_mem ? rd_job : run_reg;
        sw      = plan_reg.sw_fin || (plan_reg.cmp_id && (nxt.id != run_reg.id));
        start_t = time_reg + (sw ? TIME_OUT_W'(cfg.overhead) : '0);

        res          = '0;
        res.status   = ST_RAN;
        res.fin_id   = plan_reg.fin_id;
        unique case (plan_reg.kind)
            PK_ADDED:
            begin
                res.status = ST_ADDED;
                res.fin_id = '0;
            end
            PK_REFUSED:
            begin
                res.status = ST_REFUSED;
                res.fin_id = '0;
            end
            PK_IDLE:
            begin
                res.status = ST_IDLE;
            end
            PK_RUN:
            begin
                res.run_id   = nxt.id;
                res.switched = sw;
                res.first    = (nxt.rem == nxt.svc);
                res.start    = start_t;
                res.lvl      = plan_reg.new_lvl;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int l = 0; l < LEVELS; l++)
            begin
                cnt_reg[l]  <= '0;
                head_reg[l] <= '0;
            end
            run_reg     <= '0;
            run_lvl_reg <= '0;
            slice_reg   <= QUANTUM_RESET[0];
            time_reg    <= '0;
            plan_reg    <= '0;
        end
        else
        begin
            if (ctl.issue)
            begin
                for (int l = 0; l < LEVELS; l++)
                begin
                    cnt_reg[l]  <= cnt_next[l];
                    head_reg[l] <= head_next[l];
                end
                plan_reg <= plan_next;
            end
            if (ctl.commit)
            begin
                unique case (plan_reg.kind)
                    PK_RUN:
                    begin
                        run_reg.id  <= nxt.id;
                        run_reg.svc <= nxt.svc;
                        run_reg.rem <= (nxt.rem != '0) ? nxt.rem - TIME_BITS'(1) : nxt.rem;
                        run_lvl_reg <= plan_reg.new_lvl;
                        slice_reg   <= plan_reg.slice_base - QUANTUM_W'(1);
                        time_reg    <= start_t + TIME_OUT_W'(1);
                    end
                    PK_IDLE:
                    begin
                        run_reg.id <= '0;
                        time_reg   <= time_reg + TIME_OUT_W'(1);
                    end
                    PK_ADDED, PK_REFUSED:
                    begin
                        run_reg <= run_reg;
                    end
                endcase
            end
        end
    end

    // checks
    `MFQ_ASSERT_NXT(a_issue_spaced, ctl.issue, !ctl.issue, "back to back issue")
    `MFQ_ASSERT_NOW(a_cnt_bound, 1'b1, !cnt_over, "queue count above depth")
    `MFQ_ASSERT_NOW(a_run_has_id, ctl.commit && (res.status == ST_RAN), res.run_id != '0, "ran with no job")

endmodule

### sv/multilevel_feedback_queue_scheduler_core.sv
// Four-level feedback queue scheduler core, top level.
// Accepting an item registers its dispatch plan and any job store read; the result
// beat is registered from them at commit, which a stalled result beat holds off. No
// new item is taken until the last one commits; a tick may read one queue front from
// the job store through its registered read port. Reset: rst_n asynchronous, active
// low; queues empty, no job running, time zero, registers at their defaults, no clearing pass.
`timescale 1ns / 1ps
`include "multilevel_feedback_queue_scheduler_core_assert.svh"

module multilevel_feedback_queue_scheduler_core (
    input  logic                               clk,
    input  logic                               rst_n,
    // item channel
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               command,
    input  logic [mfq_pkg::JOB_ID_W-1:0]       job_id,
    input  logic [mfq_pkg::SVC_IN_W-1:0]       work_units,
    // result channel
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [mfq_pkg::STATUS_W-1:0]       status,
    output logic [mfq_pkg::JOB_ID_W-1:0]       run_job_id,
    output logic                               switched,
    output logic                               first_run,
    output logic [mfq_pkg::JOB_ID_W-1:0]       finished_job_id,
    output logic [mfq_pkg::TIME_OUT_W-1:0]     start_time,
    output logic [mfq_pkg::RUN_LVL_W-1:0]      run_level,
    // register write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mfq_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mfq_pkg::QUANTUM_W-1:0]      cfg_data
);
    import mfq_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_BUSY
    } state_t;

    state_t                  state_reg;
    cfg_t                    cfg_reg;
    item_t                   item;
    ctl_t                    ctl;
    result_t                 res;

    logic                    out_valid_reg;
    logic [STATUS_W-1:0]     status_reg;
    logic [JOB_ID_W-1:0]     run_job_id_reg;
    logic                    switched_reg;
    logic                    first_run_reg;
    logic [JOB_ID_W-1:0]     finished_job_id_reg;
    logic [TIME_OUT_W-1:0]   start_time_reg;
    logic [RUN_LVL_W-1:0]    run_level_reg;

    // handshake control
    assign in_stall     = (state_reg != S_IDLE);
    assign cfg_ready    = 1'b1;
    assign ctl.issue    = in_valid && !in_stall;
    assign ctl.commit   = (state_reg == S_BUSY) && (!out_valid_reg || !out_stall);

    assign item.command    = command;
    assign item.job_id     = job_id;
    assign item.work_units = work_units;

    // register writes, unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.quantum  <= QUANTUM_RESET;
            cfg_reg.overhead <= OVERHEAD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            priority if (cfg_index <= CFG_QUANTUM_LAST)
            begin
                cfg_reg.quantum[QIDX_W'(cfg_index)] <= cfg_data;
            end
            else if (cfg_index == CFG_SWITCH_OVERHEAD)
            begin
                cfg_reg.overhead <= cfg_data;
            end
            else
            begin
                cfg_reg <= cfg_reg;
            end
        end
    end

    mfq_sched u_sched (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .item  (item),
        .cfg   (cfg_reg),
        .res   (res)
    );

    // sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= S_IDLE;
            out_valid_reg       <= 1'b0;
            status_reg          <= '0;
            run_job_id_reg      <= '0;
            switched_reg        <= 1'b0;
            first_run_reg       <= 1'b0;
            finished_job_id_reg <= '0;
            start_time_reg      <= '0;
            run_level_reg       <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (ctl.issue)
                    begin
                        state_reg <= S_BUSY;
                    end
                    if (out_valid_reg && !out_stall)
                    begin
                        out_valid_reg <= 1'b0;
                    end
                end
                S_BUSY:
                begin
                    if (ctl.commit)
                    begin
                        state_reg           <= S_IDLE;
                        out_valid_reg       <= 1'b1;
                        status_reg          <= res.status;
                        run_job_id_reg      <= JOB_ID_W'(res.run_id);
                        switched_reg        <= res.switched;
                        first_run_reg       <= res.first;
                        finished_job_id_reg <= JOB_ID_W'(res.fin_id);
                        start_time_reg      <= res.start;
                        run_level_reg       <= RUN_LVL_W'(res.lvl);
                    end
                end
            endcase
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign run_job_id      = run_job_id_reg;
    assign switched        = switched_reg;
    assign first_run       = first_run_reg;
    assign finished_job_id = finished_job_id_reg;
    assign start_time      = start_time_reg;
    assign run_level       = run_level_reg;

    // checks
    `MFQ_ASSERT_NXT(a_accept_busy, in_valid && !in_stall, state_reg == S_BUSY, "accept not followed by busy")
    `MFQ_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid, "stalled beat dropped")
    `MFQ_ASSERT_NXT(a_out_stable, out_valid && out_stall, $stable(start_time), "stalled beat changed")

endmodule

### verif/tb_multilevel_feedback_queue_scheduler_core.sv
// Self-checking bench for the four-level feedback queue scheduler core.
// Depends on mfq_pkg and the scheduler RTL; a scoreboard class predicts every
// result beat while plain tasks drive items and register writes and a process drives back-pressure.
`timescale 1ns / 1ps

module tb_multilevel_feedback_queue_scheduler_core;

    import mfq_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 6;

    // register indexes below the last quantum register
    localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM2 = 3'd2;

    typedef struct packed {
        status_t                status;
        logic [JOB_ID_W-1:0]    run_id;
        logic                   sw;
        logic                   first;
        logic [JOB_ID_W-1:0]    fin_id;
        logic [TIME_OUT_W-1:0]  start;
        logic [RUN_LVL_W-1:0]   lvl;
    } sched_result_t;

    // scheduler shadow state and the queue of predicted result beats
    class sched_scoreboard;
        job_t                 store[LEVELS][QUEUE_DEPTH];
        int                   head[LEVELS];
        int                   fill[LEVELS];
        job_t                 cur;
        int                   cur_level;
        logic [QUANTUM_W-1:0] slice_left;
        logic [31:0]          now;
        logic [QUANTUM_W-1:0] quantum[NUM_QUANTA];
        logic [QUANTUM_W-1:0] overhead;
        sched_result_t        pending_results[$];
        int errors;
        int ran_cnt, idle_cnt, added_cnt, refused_cnt;
        int switch_cnt, finish_cnt, demote_cnt, blocked_cnt;

        function new();
            foreach (head[l])
            begin
                head[l] = 0;
                fill[l] = 0;
            end
            foreach (quantum[i])
            begin
                quantum[i] = QUANTUM_RESET[i];
            end
            overhead   = OVERHEAD_RESET;
            cur        = '0;
            cur_level  = 0;
            slice_left = quantum[0];
            now        = '0;
            errors     = 0;
            ran_cnt = 0; idle_cnt = 0; added_cnt = 0; refused_cnt = 0;
            switch_cnt = 0; finish_cnt = 0; demote_cnt = 0; blocked_cnt = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [QUANTUM_W-1:0] data);
            if (idx <= CFG_QUANTUM_LAST)
            begin
                quantum[idx] = data;
            end
            else if (idx == CFG_SWITCH_OVERHEAD)
            begin
                overhead = data;
            end
        endfunction

        // append one predicted beat at the back of the queue
        function void queue_result(sched_result_t r);
            pending_results = {pending_results, r};
        endfunction

        // zero quantum behaves as a one-tick slice
        function logic [QUANTUM_W-1:0] slice_for(int lvl);
            logic [QUANTUM_W-1:0] q;
            q = quantum[(lvl < NUM_QUANTA - 1) ? lvl : NUM_QUANTA - 1];
            return (q == '0) ? QUANTUM_W'(1) : q;
        endfunction

        function int first_busy_level();
            for (int l = 0; l < LEVELS; l++)
            begin
                if (fill[l] != 0)
                begin
                    return l;
                end
            end
            return LEVELS;
        endfunction

        function void append_job(int lvl, job_t j);
            store[lvl][(head[lvl] + fill[lvl]) % QUEUE_DEPTH] = j;
            fill[lvl]++;
        endfunction

        function job_t take_front(int lvl);
            job_t j;
            j = store[lvl][head[lvl]];
            head[lvl] = (head[lvl] + 1) % QUEUE_DEPTH;
            fill[lvl]--;
            return j;
        endfunction

        // advance the shadow scheduler by one accepted item
        function void schedule_item(logic cmd, logic [JOB_ID_W-1:0] id,
                                    logic [SVC_IN_W-1:0] svc);
            sched_result_t       r;
            job_t                nxt;
            logic [JOB_ID_W-1:0] prev_id;
            logic [JOB_ID_W-1:0] finished;
            logic                after_finish;
            int                  p;
            int                  target;
            r            = '0;
            finished     = '0;
            after_finish = 1'b0;

            // add: push into level 0 unless refused
            if (cmd == CMD_ADD)
            begin
                if (id == '0 || svc == '0 || fill[0] >= QUEUE_DEPTH)
                begin
                    r.status = ST_REFUSED;
                    refused_cnt++;
                end
                else
                begin
                    append_job(0, '{id: id, svc: svc, rem: svc});
                    r.status = ST_ADDED;
                    added_cnt++;
                end
                queue_result(r);
                return;
            end

            // job that used its last unit last tick is reported now
            prev_id = cur.id;
            if (cur.id != '0 && cur.rem == '0)
            begin
                finished     = cur.id;
                cur.id       = '0;
                after_finish = 1'b1;
                finish_cnt++;
            end

            if (cur.id == '0)
            begin
                p = first_busy_level();
                if (p >= LEVELS)
                begin
                    r.status = ST_IDLE;
                    r.fin_id = finished;
                    now++;
                    idle_cnt++;
                    queue_result(r);
                    return;
                end
                cur        = take_front(p);
                cur_level  = p;
                slice_left = slice_for(p);
                if (after_finish)
                begin
                    now += overhead;
                    r.sw = 1'b1;
                end
            end
            else if (slice_left == '0)
            begin
                // slice used up: demote if someone else waits
                p = first_busy_level();
                if (p >= LEVELS)
                begin
                    slice_left = slice_for(cur_level);
                end
                else
                begin
                    target = (cur_level + 1 < LEVELS) ? cur_level + 1 : LEVELS - 1;
                    if (fill[target] < QUEUE_DEPTH)
                    begin
                        append_job(target, cur);
                        p   = first_busy_level();
                        nxt = take_front(p);
                        demote_cnt++;
                    end
                    else if (p == target)
                    begin
                        nxt = take_front(p);
                        append_job(target, cur);
                        demote_cnt++;
                    end
                    else
                    begin
                        // lower level full, job stays where it is
                        nxt = cur;
                        p   = cur_level;
                        blocked_cnt++;
                    end
                    cur        = nxt;
                    cur_level  = p;
                    slice_left = slice_for(p);
                    if (nxt.id != prev_id)
                    begin
                        now += overhead;
                        r.sw = 1'b1;
                    end
                end
            end

            // run one unit
            r.first = (cur.rem == cur.svc);
            r.start = now;
            now++;
            if (cur.rem != '0)
            begin
                cur.rem--;
            end
            slice_left = slice_left - 1'b1;

            r.status = ST_RAN;
            r.run_id = cur.id;
            r.fin_id = finished;
            r.lvl    = RUN_LVL_W'(cur_level);
            ran_cnt++;
            if (r.sw)
            begin
                switch_cnt++;
            end
            queue_result(r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(logic [STATUS_W-1:0] st, logic [JOB_ID_W-1:0] run_id,
                                   logic sw, logic first, logic [JOB_ID_W-1:0] fin_id,
                                   logic [TIME_OUT_W-1:0] start, logic [RUN_LVL_W-1:0] lvl);
            sched_result_t want;
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: result beat with nothing expected, status %0d job %0d",
                         $time, st, run_id);
                return;
            end
            want = pending_results.pop_front();
            compare_field("status", 32'(want.status), 32'(st));
            compare_field("run_job_id", 32'(want.run_id), 32'(run_id));
            compare_field("switched", 32'(want.sw), 32'(sw));
            compare_field("first_run", 32'(want.first), 32'(first));
            compare_field("finished_job_id", 32'(want.fin_id), 32'(fin_id));
            compare_field("start_time", want.start, start);
            compare_field("run_level", 32'(want.lvl), 32'(lvl));
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic                  command = CMD_ADD;
    logic [JOB_ID_W-1:0]   job_id = '0;
    logic [SVC_IN_W-1:0]   work_units = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [STATUS_W-1:0]   status;
    logic [JOB_ID_W-1:0]   run_job_id;
    logic                  switched;
    logic                  first_run;
    logic [JOB_ID_W-1:0]   finished_job_id;
    logic [TIME_OUT_W-1:0] start_time;
    logic [RUN_LVL_W-1:0]  run_level;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [QUANTUM_W-1:0]  cfg_data = '0;

    sched_scoreboard sb;
    bit              idle_on = 1'b1;
    int              stuck_cycles = 0;
    int              settings_cnt = 1;

    multilevel_feedback_queue_scheduler_core dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .command         (command),
        .job_id          (job_id),
        .work_units      (work_units),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .run_job_id      (run_job_id),
        .switched        (switched),
        .first_run       (first_run),
        .finished_job_id (finished_job_id),
        .start_time      (start_time),
        .run_level       (run_level),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // wait length before a beat, zero during calm stretches
    function automatic int draw_gap();
        return idle_on ? $urandom_range(0, 19) : 0;
    endfunction

    // mostly short jobs, a few long ones, a few zero-length refusals
    function automatic logic [SVC_IN_W-1:0] draw_service(int long_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            return '0;
        end
        if (r < 3 + long_pct)
        begin
            return SVC_IN_W'($urandom_range(1, 65535));
        end
        if (r < 30)
        begin
            return SVC_IN_W'($urandom_range(9, 64));
        end
        return SVC_IN_W'($urandom_range(1, 8));
    endfunction

    // one item beat; valid stays high afterwards
    task automatic send_item(logic cmd, logic [JOB_ID_W-1:0] id, logic [SVC_IN_W-1:0] svc);
        int gap;
        gap = draw_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   = 1'b1;
        command    = cmd;
        job_id     = id;
        work_units = svc;
        do @(posedge clk); while (in_stall !== 1'b0);
        sb.schedule_item(cmd, id, svc);
    endtask

    // hold off the sender until every result beat has arrived
    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending_results.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [QUANTUM_W-1:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        sb.set_reg(idx, data);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic load_setting(logic [QUANTUM_W-1:0] q0, logic [QUANTUM_W-1:0] q1,
                                logic [QUANTUM_W-1:0] q2, logic [QUANTUM_W-1:0] q3,
                                logic [QUANTUM_W-1:0] ov);
        wait_drained();
        write_reg(CFG_QUANTUM0, q0);
        write_reg(CFG_QUANTUM1, q1);
        write_reg(CFG_QUANTUM2, q2);
        write_reg(CFG_QUANTUM_LAST, q3);
        write_reg(CFG_SWITCH_OVERHEAD, ov);
        settings_cnt++;
    endtask

    // random mix of adds and ticks with calm stretches and one drain pause
    task automatic random_phase(int n_items, int add_pct, int long_pct);
        logic [JOB_ID_W-1:0] id;
        int                  pause_at;
        pause_at = $urandom_range(n_items / 4, 3 * n_items / 4);
        for (int i = 0; i < n_items; i++)
        begin
            if ($urandom_range(0, 29) == 0)
            begin
                idle_on = !idle_on;
            end
            if (i == pause_at)
            begin
                wait_drained();
            end
            if ($urandom_range(0, 99) < add_pct)
            begin
                id = ($urandom_range(0, 19) == 0) ? '0 : JOB_ID_W'($urandom_range(1, 255));
                send_item(CMD_ADD, id, draw_service(long_pct));
            end
            else
            begin
                send_item(CMD_TICK, JOB_ID_W'($urandom), SVC_IN_W'($urandom));
            end
        end
    endtask

    // result side: random stall per beat, check at the accepting edge
    initial
    begin
        int hold;
        @(posedge rst_n);
        forever
        begin
            hold = draw_gap();
            @(negedge clk);
            if (hold > 0)
            begin
                out_stall = 1'b1;
                repeat (hold) @(negedge clk);
                out_stall = 1'b0;
            end
            do @(posedge clk); while (!(out_valid === 1'b1 && out_stall === 1'b0));
            sb.check_result(status, run_job_id, switched, first_run, finished_job_id,
                            start_time, run_level);
        end
    end

    // watchdog on cycles with no beat on any channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid === 1'b1 && in_stall === 1'b0) ||
                (out_valid === 1'b1 && out_stall === 1'b0) ||
                (cfg_valid === 1'b1 && cfg_ready === 1'b1))
            begin
                stuck_cycles <= 0;
            end
            else if (stuck_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no beat for %0d cycles", $time, stuck_cycles);
                $display("CHECK FAILED");
                $finish;
            end
            else
            begin
                stuck_cycles <= stuck_cycles + 1;
            end
        end
    end

    // main sequence
    initial
    begin
        sb = new();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: idle tick, refusals, full level 0, first dispatches
        idle_on = 1'b0;
        send_item(CMD_TICK, '0, '0);
        send_item(CMD_ADD, '0, 16'd5);
        send_item(CMD_ADD, 8'd7, '0);
        for (int k = 0; k < QUEUE_DEPTH; k++)
        begin
            if (k == QUEUE_DEPTH - 1)
            begin
                send_item(CMD_ADD, 8'd255, 16'hFFFF);
            end
            else
            begin
                send_item(CMD_ADD, JOB_ID_W'(k + 1), (k == 0) ? 16'd1 : SVC_IN_W'(k % 5 + 1));
            end
        end
        send_item(CMD_ADD, 8'd200, 16'd3);
        repeat (4) send_item(CMD_TICK, 8'hFF, 16'hFFFF);
        idle_on = 1'b1;

        // random phases across register settings
        random_phase(95, 45, 2);
        load_setting(8'd1, 8'd1, 8'd1, 8'd1, 8'd3);
        random_phase(100, 70, 6);
        load_setting(8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
        random_phase(95, 40, 2);
        load_setting(8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        random_phase(95, 50, 2);
        load_setting(8'd2, 8'd3, 8'd5, 8'd7, 8'd1);
        random_phase(95, 35, 1);
        load_setting(QUANTUM_W'($urandom_range(1, 16)), QUANTUM_W'($urandom_range(1, 16)),
                     QUANTUM_W'($urandom_range(1, 16)), QUANTUM_W'($urandom_range(1, 16)),
                     QUANTUM_W'($urandom_range(0, 8)));
        random_phase(100, 45, 2);
        load_setting(8'd1, 8'd2, 8'd4, 8'd8, 8'd255);
        random_phase(100, 30, 1);

        // let the last beats drain
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending_results.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d runs, %0d idle ticks, %0d adds, %0d refused adds",
                 sb.ran_cnt, sb.idle_cnt, sb.added_cnt, sb.refused_cnt);
        $display("%0d switches, %0d finishes, %0d demotions, %0d blocked, %0d settings",
                 sb.switch_cnt, sb.finish_cnt, sb.demote_cnt, sb.blocked_cnt, settings_cnt);
        if (sb.errors == 0 && sb.pending_results.size() == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+sv
sv/mfq_pkg.sv
sv/mfq_qmem.sv
sv/mfq_sched.sv
sv/multilevel_feedback_queue_scheduler_core.sv
verif/tb_multilevel_feedback_queue_scheduler_core.sv
